>>> hw/rtl/lzsr_pkg.sv
// Shared types and constants for the longest zero-sum run block.
// No dependencies; compiled first.
package lzsr_pkg;

  localparam int SUM_W        = 32;
  localparam int BEST_W       = 11;
  localparam int EPOCH_W      = 4;
  localparam int HASH_MOD     = 1009;
  localparam int HASH_REM_W   = 10;
  localparam int HASH_A_STEPS = 5;
  localparam int STEP_CNT_W   = 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_HASH_A,
    ST_HASH_B,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } lzsr_state_t;

endpackage

>>> hw/rtl/lzsr_if.sv
// Valid/ready channel interfaces for the longest zero-sum run block.
// Depends on lzsr_pkg for the result field widths.
interface lzsr_in_if #(
  parameter int VALUE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          first;

  modport source (output valid, output value, output first, input ready);
  modport sink   (input valid, input value, input first, output ready);
endinterface

interface lzsr_out_if;
  import lzsr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BEST_W-1:0] best_len;
  logic              overflow;

  modport source (output valid, output best_len, output overflow, input ready);
  modport sink   (input valid, input best_len, input overflow, output ready);
endinterface

>>> hw/rtl/longest_zero_sum_run.sv
// Longest zero-sum run over a stream of signed words, one result word per input word.
// Depends on lzsr_pkg and the channel interfaces in lzsr_if.sv.
//
// Each input word adds to a 32-bit running prefix sum; a hashed store (linear probing,
// one write and one read port) records where each distinct prefix sum first appeared,
// and the result word carries the longest zero-sum run in the current array plus a
// sticky overflow flag. One word at a time is processed: accept it, form the sum, run
// HASH_A_STEPS steps in the shared fold unit (2^10 is 15 mod 1009), then the final
// compare-subtract and the reduction mod STORE_DEPTH to form the home slot, then a read
// and a check per probe of the store, and last the hand-over of the result; a frozen or
// over-long array skips the hash and the probes. The hand-over waits while the previous
// result word is still held by out_ch.ready. After reset the store is swept, slot by
// slot, before the first word is taken, and again on every fifteenth new array, when
// the array tag wraps.
module longest_zero_sum_run
  import lzsr_pkg::*;
#(
  parameter int MAX_ITEMS   = 1024,
  parameter int STORE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  lzsr_in_if.sink    in_ch,
  lzsr_out_if.source out_ch
);

  localparam int SW        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PW        = $clog2(MAX_ITEMS + 1);
  localparam int ENTRY_W   = EPOCH_W + SUM_W + PW;
  localparam int RED_SHIFT = HASH_REM_W + SW;
  localparam int RM_W      = HASH_REM_W + 2;

  localparam logic [SW-1:0]         SLOT_LAST  = SW'(STORE_DEPTH - 1);
  localparam logic [SW:0]           PROBE_LAST = (SW + 1)'(STORE_DEPTH - 1);
  localparam logic [PW-1:0]         POS_FULL   = PW'(MAX_ITEMS);
  localparam logic [SUM_W-1:0]      FOLD_MUL   = SUM_W'((1 << HASH_REM_W) - HASH_MOD);
  localparam logic [HASH_REM_W-1:0] MOD_V      = HASH_REM_W'(HASH_MOD);
  localparam logic [HASH_REM_W-1:0] DEPTH_V    = HASH_REM_W'(STORE_DEPTH);
  localparam logic [RM_W-1:0]       RED_MUL    =
    RM_W'(((64'd1 << RED_SHIFT) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH));
  localparam logic [EPOCH_W-1:0]    EPOCH_MAX  = '1;
  localparam logic [EPOCH_W-1:0]    EPOCH_ONE  = EPOCH_W'(1);

  lzsr_state_t state_r, state_nxt;

  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [PW-1:0]         best_r, best_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [EPOCH_W-1:0]    epoch_r, epoch_nxt;
  logic                  resume_r, resume_nxt;
  logic [SW-1:0]         clr_idx_r, clr_idx_nxt;
  logic [SUM_W-1:0]      elem_r, elem_nxt;
  logic [SUM_W-1:0]      cand_r, cand_nxt;
  logic [SUM_W-1:0]      fold_r, fold_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic [SW:0]           probe_r, probe_nxt;

  logic              out_valid_r;
  logic [BEST_W-1:0] out_best_r;
  logic              out_ovf_r;

  logic [ENTRY_W-1:0] mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic               mem_we;
  logic [SW-1:0]      mem_wa;
  logic [ENTRY_W-1:0] mem_wd;

  logic                       in_accept;
  logic                       out_load;
  logic [SUM_W-1:0]           sum_add;
  logic [SUM_W-1:0]           sum_mag;
  logic [SUM_W-1:0]           fold_hi;
  logic [SUM_W-1:0]           fold_sum;
  logic [HASH_REM_W-1:0]      hash_val;
  logic [HASH_REM_W+RM_W-1:0] red_prod;
  logic [HASH_REM_W-1:0]      red_q;
  logic [HASH_REM_W-1:0]      red_mod;
  logic [EPOCH_W-1:0]         rd_tag;
  logic [SUM_W-1:0]           rd_key;
  logic [PW-1:0]              rd_pos;
  logic                       hit_valid;
  logic                       hit_key;
  logic [PW-1:0]              pos_plus;
  logic [PW-1:0]              run_len;
  logic [PW-1:0]              zero_best;
  logic [PW-1:0]              found_best;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign sum_add  = sum_r + elem_r;
  assign sum_mag  = sum_add[SUM_W-1] ? (~sum_add + 1'b1) : sum_add;
  assign fold_hi  = fold_r >> HASH_REM_W;
  assign fold_sum = fold_hi * FOLD_MUL
                  + {{(SUM_W - HASH_REM_W){1'b0}}, fold_r[HASH_REM_W-1:0]};
  assign hash_val = (fold_r[HASH_REM_W-1:0] >= MOD_V) ? fold_r[HASH_REM_W-1:0] - MOD_V
                                                      : fold_r[HASH_REM_W-1:0];
  assign red_prod = hash_val * RED_MUL;
  assign red_q    = HASH_REM_W'(red_prod >> RED_SHIFT);
  assign red_mod  = hash_val - red_q * DEPTH_V;

  assign rd_tag     = rd_q[ENTRY_W-1 -: EPOCH_W];
  assign rd_key     = rd_q[PW +: SUM_W];
  assign rd_pos     = rd_q[PW-1:0];
  assign hit_valid  = (rd_tag == epoch_r);
  assign hit_key    = (rd_key == cand_r);
  assign pos_plus   = pos_r + 1'b1;
  assign run_len    = pos_r - rd_pos;
  assign zero_best  = ((cand_r == '0) && (pos_plus > best_r)) ? pos_plus : best_r;
  assign found_best = (run_len > zero_best) ? run_len : zero_best;

  // Datapath next values
  always_comb begin
    sum_nxt     = sum_r;
    pos_nxt     = pos_r;
    best_nxt    = best_r;
    ovf_nxt     = ovf_r;
    epoch_nxt   = epoch_r;
    resume_nxt  = resume_r;
    clr_idx_nxt = clr_idx_r;
    elem_nxt    = elem_r;
    cand_nxt    = cand_r;
    fold_nxt    = fold_r;
    cnt_nxt     = cnt_r;
    slot_nxt    = slot_r;
    probe_nxt   = probe_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_accept) begin
          elem_nxt = SUM_W'(signed'(in_ch.value));
          if (in_ch.first) begin
            sum_nxt     = '0;
            pos_nxt     = '0;
            best_nxt    = '0;
            ovf_nxt     = 1'b0;
            clr_idx_nxt = '0;
            resume_nxt  = (epoch_r == EPOCH_MAX);
            epoch_nxt   = (epoch_r == EPOCH_MAX) ? EPOCH_ONE : epoch_r + 1'b1;
          end
        end
      end
      ST_START: begin
        cand_nxt = sum_add;
        fold_nxt = sum_mag;
        cnt_nxt  = STEP_CNT_W'(HASH_A_STEPS - 1);
        if (!ovf_r && (pos_r == POS_FULL)) begin
          ovf_nxt = 1'b1;
        end
      end
      ST_HASH_A: begin
        fold_nxt = fold_sum;
        cnt_nxt  = cnt_r - 1'b1;
      end
      ST_HASH_B: begin
        slot_nxt  = SW'(red_mod);
        probe_nxt = '0;
      end
      ST_READ: begin
      end
      ST_CHECK: begin
        if (!hit_valid) begin
          best_nxt = zero_best;
          sum_nxt  = cand_r;
          pos_nxt  = pos_plus;
        end else if (hit_key) begin
          best_nxt = found_best;
          sum_nxt  = cand_r;
          pos_nxt  = pos_plus;
        end else if (probe_r == PROBE_LAST) begin
          ovf_nxt = 1'b1;
        end else begin
          probe_nxt = probe_r + 1'b1;
          slot_nxt  = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == SLOT_LAST) begin
          state_nxt = resume_r ? ST_START : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_ch.first && (epoch_r == EPOCH_MAX)) ? ST_CLEAR : ST_START;
        end
      end
      ST_START: begin
        state_nxt = (ovf_r || (pos_r == POS_FULL)) ? ST_DONE : ST_HASH_A;
      end
      ST_HASH_A: begin
        if (cnt_r == '0) begin
          state_nxt = ST_HASH_B;
        end
      end
      ST_HASH_B: begin
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = (!hit_valid || hit_key || (probe_r == PROBE_LAST)) ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs and store write port
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = slot_r;
    mem_wd      = {epoch_r, cand_r, pos_r};
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx_r;
        mem_wd = '0;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_CHECK: begin
        mem_we = !hit_valid;
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.best_len = out_best_r;
  assign out_ch.overflow = out_ovf_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sum_r       <= '0;
      pos_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      epoch_r     <= EPOCH_ONE;
      resume_r    <= 1'b0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      pos_r       <= pos_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
      epoch_r     <= epoch_nxt;
      resume_r    <= resume_nxt;
      clr_idx_r   <= clr_idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    elem_r  <= elem_nxt;
    cand_r  <= cand_nxt;
    fold_r  <= fold_nxt;
    cnt_r   <= cnt_nxt;
    slot_r  <= slot_nxt;
    probe_r <= probe_nxt;
    if (out_load) begin
      out_best_r <= BEST_W'(best_r);
      out_ovf_r  <= ovf_r;
    end
  end

endmodule
